// ===== rtl/fpr_pkg.sv =====
// Shared constants, command codes and the cell-to-cell link types of the fault point registry.
package fpr_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int ID_W          = 32;
    localparam int VAL_W         = 32;
    localparam int CMD_W         = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_HIT    = 3'd0,
        CMD_ARM    = 3'd1,
        CMD_DISARM = 3'd2,
        CMD_QUERY  = 3'd3,
        CMD_CLEAR  = 3'd4
    } cmd_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // Broadcast from the control to every cell.
    typedef struct packed {
        logic             fire;
        logic [CMD_W-1:0] cmd;
        logic [ID_W-1:0]  key;
        logic [VAL_W-1:0] value;
        logic             any_match;
    } bcast_t;

    // Handed from one cell to its right neighbor.
    typedef struct packed {
        logic             found;
        logic             free_seen;
        logic [VAL_W-1:0] inject;
        logic [VAL_W-1:0] hits;
    } link_t;

endpackage

// ===== rtl/fpr_cell.sv =====
// One slot of the fault point table: id compare, first-free claim and entry update.
module fpr_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  fpr_pkg::bcast_t bc,
    input  fpr_pkg::link_t link_in,
    output fpr_pkg::link_t link_out
);

    logic                      used_reg,  used_next;
    logic                      armed_reg, armed_next;
    logic [fpr_pkg::ID_W-1:0]  id_reg,    id_next;
    logic [fpr_pkg::VAL_W-1:0] value_reg, value_next;
    logic [fpr_pkg::VAL_W-1:0] hits_reg,  hits_next;
    logic                      match;
    logic                      create_ok;

    assign match     = used_reg && (id_reg == bc.key);
    // claim only if no slot matches and no lower slot is free
    assign create_ok = !used_reg && !link_in.free_seen && !bc.any_match;

    always_comb
    begin
        link_out.found     = link_in.found | match;
        link_out.free_seen = link_in.free_seen | !used_reg;
        link_out.inject    = link_in.inject |
                             ((match && armed_reg) ? value_reg : '0);
        link_out.hits      = link_in.hits | (match ? hits_reg : '0);
    end

    always_comb
    begin
        used_next  = used_reg;
        armed_next = armed_reg;
        id_next    = id_reg;
        value_next = value_reg;
        hits_next  = hits_reg;
        if (bc.fire)
        begin
            case (fpr_pkg::cmd_t'(bc.cmd))
                fpr_pkg::CMD_HIT:
                begin
                    if (match)
                    begin
                        hits_next = hits_reg + 1'b1;
                    end
                    else if (create_ok)
                    begin
                        used_next  = 1'b1;
                        id_next    = bc.key;
                        armed_next = 1'b0;
                        value_next = '0;
                        hits_next  = {{(fpr_pkg::VAL_W-1){1'b0}}, 1'b1};
                    end
                end
                fpr_pkg::CMD_ARM:
                begin
                    if (match)
                    begin
                        armed_next = 1'b1;
                        value_next = bc.value;
                    end
                    else if (create_ok)
                    begin
                        used_next  = 1'b1;
                        id_next    = bc.key;
                        armed_next = 1'b1;
                        value_next = bc.value;
                        hits_next  = '0;
                    end
                end
                fpr_pkg::CMD_DISARM:
                begin
                    if (match)
                    begin
                        armed_next = 1'b0;
                    end
                end
                fpr_pkg::CMD_CLEAR:
                begin
                    used_next  = 1'b0;
                    armed_next = 1'b0;
                    id_next    = '0;
                    value_next = '0;
                    hits_next  = '0;
                end
                default:
                begin
                    // query and unused codes leave the slot alone
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= 1'b0;
            armed_reg <= 1'b0;
            id_reg    <= '0;
            value_reg <= '0;
            hits_reg  <= '0;
        end
        else
        begin
            used_reg  <= used_next;
            armed_reg <= armed_next;
            id_reg    <= id_next;
            value_reg <= value_next;
            hits_reg  <= hits_next;
        end
    end

endmodule

// ===== rtl/fault_point_registry_core.sv =====
// Top level of the fault point registry: command capture, cell chain and response register.
// A command word accepted while idle is captured, then evaluated by the cell chain in the
// execute state once the response register is free, and lands in the response register.
// Commands are taken one at a time: the capture/execute sequencer stalls while executing.
// A new command is taken while the previous response still waits to be taken.
// Reset (rst_n, async, active low) empties every slot and drops all valid flags.
module fault_point_registry_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_stall,
    input  logic [fpr_pkg::CMD_W-1:0]        command,
    input  logic [fpr_pkg::ID_W-1:0]         point_id,
    input  logic signed [fpr_pkg::VAL_W-1:0] arm_value,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output logic signed [fpr_pkg::VAL_W-1:0] inject_result,
    output logic [fpr_pkg::VAL_W-1:0]        hit_total,
    output logic                             entry_present,
    output logic                             table_full
);

    // Sequencer state
    fpr_pkg::state_t state_reg, state_next;

    // Captured command word
    logic [fpr_pkg::CMD_W-1:0] cmd_reg;
    logic [fpr_pkg::ID_W-1:0]  key_reg;
    logic [fpr_pkg::VAL_W-1:0] value_reg;

    // Response register
    logic                      rsp_valid_reg, rsp_valid_next;
    logic [fpr_pkg::VAL_W-1:0] inject_reg,  inject_next;
    logic [fpr_pkg::VAL_W-1:0] total_reg,   total_next;
    logic                      present_reg, present_next;
    logic                      full_reg,    full_next;

    logic            cmd_accept;
    logic            rsp_free;
    logic            fire;
    logic            any_match;
    logic            any_free;
    fpr_pkg::bcast_t bc;
    fpr_pkg::link_t  links [fpr_pkg::TABLE_ENTRIES+1];

    assign cmd_stall  = (state_reg != fpr_pkg::ST_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;
    // the response register can take a new word when empty or being drained
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign fire       = (state_reg == fpr_pkg::ST_EXEC) && rsp_free;

    // -------------------------------------------------------------------
    // Cell chain: slot 0 on the left; match and free flags ripple right,
    // and the matched slot ORs its read data into the link.
    // -------------------------------------------------------------------
    assign links[0] = '0;

    assign any_match = links[fpr_pkg::TABLE_ENTRIES].found;
    assign any_free  = links[fpr_pkg::TABLE_ENTRIES].free_seen;

    always_comb
    begin
        bc.fire      = fire;
        bc.cmd       = cmd_reg;
        bc.key       = key_reg;
        bc.value     = value_reg;
        bc.any_match = any_match;
    end

    for (genvar g = 0; g < fpr_pkg::TABLE_ENTRIES; g++)
    begin : g_cell
        fpr_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .bc       (bc),
            .link_in  (links[g]),
            .link_out (links[g+1])
        );
    end

    // -------------------------------------------------------------------
    // Sequencer and response formatting
    // -------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        inject_next    = inject_reg;
        total_next     = total_reg;
        present_next   = present_reg;
        full_next      = full_reg;

        case (state_reg)
            fpr_pkg::ST_IDLE:
            begin
                if (cmd_accept)
                begin
                    state_next = fpr_pkg::ST_EXEC;
                end
            end
            fpr_pkg::ST_EXEC:
            begin
                if (fire)
                begin
                    state_next     = fpr_pkg::ST_IDLE;
                    rsp_valid_next = 1'b1;
                    inject_next    = '0;
                    total_next     = '0;
                    present_next   = 1'b0;
                    full_next      = 1'b0;
                    case (fpr_pkg::cmd_t'(cmd_reg))
                        fpr_pkg::CMD_HIT:
                        begin
                            // a freshly created entry is unarmed, so a miss reads 0
                            inject_next  = links[fpr_pkg::TABLE_ENTRIES].inject;
                            present_next = any_match || any_free;
                            full_next    = !any_match && !any_free;
                        end
                        fpr_pkg::CMD_ARM:
                        begin
                            present_next = any_match || any_free;
                            full_next    = !any_match && !any_free;
                        end
                        fpr_pkg::CMD_DISARM:
                        begin
                            present_next = any_match;
                        end
                        fpr_pkg::CMD_QUERY:
                        begin
                            total_next   = links[fpr_pkg::TABLE_ENTRIES].hits;
                            present_next = any_match;
                        end
                        default:
                        begin
                            // clear-all and unused codes answer all zero
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = fpr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fpr_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            cmd_reg   <= command;
            key_reg   <= point_id;
            value_reg <= $unsigned(arm_value);
        end
        inject_reg  <= inject_next;
        total_reg   <= total_next;
        present_reg <= present_next;
        full_reg    <= full_next;
    end

    assign rsp_valid     = rsp_valid_reg;
    assign inject_result = $signed(inject_reg);
    assign hit_total     = total_reg;
    assign entry_present = present_reg;
    assign table_full    = full_reg;

endmodule
